>>> rtl/core/pcjp_pkg.sv
package pcjp_pkg;

  // Build-time choices
  localparam int CORDIC_STEPS = 16;
  localparam int COORD_BITS   = 16;

  // Field widths
  localparam int ANG_W   = 17;
  localparam int JOINT_W = 16;
  localparam int LINK_W  = 10;
  localparam int SUM_W   = 16;
  localparam int WORK_W  = 18;
  localparam int WIDE_W  = 32;

  localparam logic [LINK_W-1:0] LINK_RESET = 10'd50;

  // Angle sum wraps at one full turn in hundredths of a degree
  localparam logic [SUM_W-1:0]         SUM_LIMIT = 16'd36000;
  localparam logic signed [WORK_W-1:0] WORK_TURN = 18'sd36000;

  // Shared multiplier
  localparam int MUL_W = 27;
  localparam int PROD_W = 2 * MUL_W;

  // Binary angle: b = s*QUOT + (s*REM + BIAS) / 1125, 2^27 = 1125*QUOT + REM
  localparam logic signed [MUL_W-1:0] BA_REM   = 27'sd728;
  localparam logic signed [MUL_W-1:0] BA_QUOT  = 27'sd119304;
  localparam logic signed [MUL_W-1:0] BA_BIAS  = 27'sd562;
  localparam logic signed [MUL_W-1:0] BA_RECIP = 27'sd61083980;
  localparam int BA_SHIFT = 36;
  localparam int QLO_W    = 15;
  localparam int BANG_W   = 32;

  // CORDIC
  localparam int ITER_W     = $clog2(CORDIC_STEPS);
  localparam int ATAN_IDX_W = 5;
  localparam int XY_W       = 34;
  localparam int Z_W        = 33;
  localparam logic signed [XY_W-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

  // Coordinate limits
  localparam logic signed [WIDE_W-1:0] COORD_MAX = (32'sd1 <<< (COORD_BITS - 1)) - 32'sd1;
  localparam logic signed [WIDE_W-1:0] COORD_MIN = -(32'sd1 <<< (COORD_BITS - 1));

  typedef enum logic [3:0] {
    S_IDLE,
    S_WRAP,
    S_BA1,
    S_BA2,
    S_BA3,
    S_CORD,
    S_ROUND,
    S_STEPX,
    S_STEPY
  } pcjp_state_t;

  typedef struct packed {
    logic              load;
    logic              step;
    logic [ITER_W-1:0] idx;
  } pcjp_cordic_ctrl_t;

  function automatic logic signed [COORD_BITS-1:0] sat_coord(
    input logic signed [WIDE_W-1:0] v
  );
    if (v > COORD_MAX) begin
      return COORD_MAX[COORD_BITS-1:0];
    end else if (v < COORD_MIN) begin
      return COORD_MIN[COORD_BITS-1:0];
    end
    return v[COORD_BITS-1:0];
  endfunction

endpackage

>>> rtl/core/pcjp_if.sv
interface pcjp_in_if;
  import pcjp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] angle_centideg;
  logic                    chain_start;
  logic signed [JOINT_W-1:0] base_x;
  logic signed [JOINT_W-1:0] base_y;

  modport source (output valid, output angle_centideg, output chain_start,
                  output base_x, output base_y, input ready);
  modport sink (input valid, input angle_centideg, input chain_start,
                input base_x, input base_y, output ready);
endinterface

interface pcjp_out_if;
  import pcjp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [JOINT_W-1:0] joint_x;
  logic signed [JOINT_W-1:0] joint_y;

  modport source (output valid, output joint_x, output joint_y, input ready);
  modport sink (input valid, input joint_x, input joint_y, output ready);
endinterface

>>> rtl/core/pcjp_mul.sv
module pcjp_mul (
  input  logic                             clk,
  input  logic signed [pcjp_pkg::MUL_W-1:0]  a,
  input  logic signed [pcjp_pkg::MUL_W-1:0]  b,
  output logic signed [pcjp_pkg::PROD_W-1:0] p_r
);
  import pcjp_pkg::*;

  // Register the product; the sequencer reads it in the cycle after issue
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

>>> rtl/core/pcjp_cordic.sv
module pcjp_cordic (
  input  logic                                clk,
  input  pcjp_pkg::pcjp_cordic_ctrl_t         ctrl,
  input  logic signed [pcjp_pkg::Z_W-1:0]     z0,
  output logic signed [pcjp_pkg::XY_W-1:0]    x_r,
  output logic signed [pcjp_pkg::XY_W-1:0]    y_r
);
  import pcjp_pkg::*;

  logic signed [Z_W-1:0]  z_r;
  logic signed [XY_W-1:0] x_nxt, y_nxt, x_sh, y_sh;
  logic signed [Z_W-1:0]  z_nxt;
  logic [Z_W-1:0]         atan_v;

  // Arctangent of 2^-i in binary-angle units (full turn = 2^32)
  function automatic logic [Z_W-1:0] atan_lookup(input logic [ATAN_IDX_W-1:0] i);
    unique case (i)
      5'd0:  return 33'd536870912;
      5'd1:  return 33'd316933406;
      5'd2:  return 33'd167458907;
      5'd3:  return 33'd85004756;
      5'd4:  return 33'd42667331;
      5'd5:  return 33'd21354465;
      5'd6:  return 33'd10679838;
      5'd7:  return 33'd5340245;
      5'd8:  return 33'd2670163;
      5'd9:  return 33'd1335087;
      5'd10: return 33'd667544;
      5'd11: return 33'd333772;
      5'd12: return 33'd166886;
      5'd13: return 33'd83443;
      5'd14: return 33'd41722;
      5'd15: return 33'd20861;
      5'd16: return 33'd10430;
      5'd17: return 33'd5215;
      5'd18: return 33'd2608;
      5'd19: return 33'd1304;
      5'd20: return 33'd652;
      5'd21: return 33'd326;
      5'd22: return 33'd163;
      5'd23: return 33'd81;
      default: return '0;
    endcase
  endfunction

  always_comb begin
    x_sh   = y_r >>> ctrl.idx;
    y_sh   = x_r >>> ctrl.idx;
    atan_v = atan_lookup(ATAN_IDX_W'(ctrl.idx));
    if (!z_r[Z_W-1]) begin
      x_nxt = x_r - x_sh;
      y_nxt = y_r + y_sh;
      z_nxt = z_r - signed'(atan_v);
    end else begin
      x_nxt = x_r + x_sh;
      y_nxt = y_r - y_sh;
      z_nxt = z_r + signed'(atan_v);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x_r <= GAIN_Q30;
      y_r <= '0;
      z_r <= z0;
    end else if (ctrl.step) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

endmodule

>>> rtl/core/planar_chain_joint_points.sv
// Planar chain forward kinematics. Each request carries one joint angle in
// hundredths of a degree; a request with chain_start set also loads the base
// point and clears the running angle sum. The block answers every request
// with the current joint point, then adds the angle to the sum (modulo 36000)
// and moves the point by link_length*sin and link_length*cos of the sum, so a
// chain's last angle never shows. link_length is written through cfg_we /
// cfg_wdata only while the block is idle (the user's rule; the block does
// not enforce it) and resets to 50. Before the next request is accepted, the
// sequencer wraps the sum into one turn and runs three passes
// through the shared multiplier for the binary angle, CORDIC_STEPS rotations
// on the shared CORDIC stage and two more multiplier passes for the x and y
// steps. The answer sits in an output register while the move is worked out;
// the next request is taken only once that answer has left or leaves in the
// same cycle, so a stalled sink can hold off the next request.
module planar_chain_joint_points (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pcjp_pkg::LINK_W-1:0]    cfg_wdata,
  pcjp_in_if.sink                        in_req,
  pcjp_out_if.source                     out_res
);
  import pcjp_pkg::*;

  // Sequencer and architectural state
  pcjp_state_t              state_r, state_nxt;
  logic [ITER_W-1:0]        iter_r, iter_nxt;
  logic signed [WORK_W-1:0] work_r, work_nxt;
  logic [SUM_W-1:0]         sum_r, sum_nxt;
  logic signed [COORD_BITS-1:0] px_r, px_nxt, py_r, py_nxt;
  logic [LINK_W-1:0]        link_r, link_nxt;
  logic                     flip_r, flip_nxt;
  logic [QLO_W-1:0]         qlo_r, qlo_nxt;
  logic signed [JOINT_W-1:0] cos_r, cos_nxt;

  // Output register
  logic                      out_vld_r, out_vld_nxt;
  logic signed [JOINT_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;

  // Shared units
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  pcjp_cordic_ctrl_t        cctl;
  logic signed [Z_W-1:0]    cz0;
  logic signed [XY_W-1:0]   cx, cy, xf, yf;
  logic signed [JOINT_W-1:0] sin_q15, cos_q15;

  // Helpers
  logic                          in_rdy;
  logic signed [COORD_BITS-1:0]  start_x, start_y;
  logic signed [WIDE_W-1:0]      start_xw, start_yw, px_w, py_w;
  logic signed [WORK_W-1:0]      work_start;
  logic [BANG_W-1:0]             bang, bang_f;
  logic                          bang_flip;
  logic signed [MUL_W-1:0]       link_m;

  localparam logic signed [XY_W-1:0] Q15_HALF = 34'sd16384;
  localparam logic signed [XY_W-1:0] Q15_MAX  = 34'sd32767;
  localparam logic signed [XY_W-1:0] Q15_MIN  = -34'sd32768;

  // Round Q4.30 to Q1.15 (floor after half-step bias), then clamp
  function automatic logic signed [JOINT_W-1:0] to_q15(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] t;
    t = (v + Q15_HALF) >>> 15;
    if (t > Q15_MAX) begin
      return Q15_MAX[JOINT_W-1:0];
    end else if (t < Q15_MIN) begin
      return Q15_MIN[JOINT_W-1:0];
    end
    return t[JOINT_W-1:0];
  endfunction

  // Divide the product by 2^15, truncating toward zero; |product| < 2^26
  function automatic logic signed [WIDE_W-1:0] step_trunc(input logic signed [PROD_W-1:0] p);
    logic signed [WIDE_W-1:0] v;
    v = p[WIDE_W-1:0];
    if (v[WIDE_W-1]) begin
      v = v + 32'sd32767;
    end
    return v >>> 15;
  endfunction

  pcjp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  pcjp_cordic u_cordic (
    .clk  (clk),
    .ctrl (cctl),
    .z0   (cz0),
    .x_r  (cx),
    .y_r  (cy)
  );

  // Base point on chain start, otherwise the point held from the last joint
  assign start_x  = in_req.chain_start ?
                    sat_coord({{(WIDE_W-JOINT_W){in_req.base_x[JOINT_W-1]}}, in_req.base_x}) :
                    px_r;
  assign start_y  = in_req.chain_start ?
                    sat_coord({{(WIDE_W-JOINT_W){in_req.base_y[JOINT_W-1]}}, in_req.base_y}) :
                    py_r;
  assign start_xw = {{(WIDE_W-COORD_BITS){start_x[COORD_BITS-1]}}, start_x};
  assign start_yw = {{(WIDE_W-COORD_BITS){start_y[COORD_BITS-1]}}, start_y};
  assign px_w     = {{(WIDE_W-COORD_BITS){px_r[COORD_BITS-1]}}, px_r};
  assign py_w     = {{(WIDE_W-COORD_BITS){py_r[COORD_BITS-1]}}, py_r};

  // Raw sum before wrap: cleared sum on chain start
  assign work_start = signed'({{(WORK_W-SUM_W){1'b0}},
                               (in_req.chain_start ? '0 : sum_r)}) +
                      {{(WORK_W-ANG_W){in_req.angle_centideg[ANG_W-1]}},
                       in_req.angle_centideg};

  // Binary angle; fold the left half-plane onto the right and flag the negation
  assign bang      = mul_p[BANG_W-1:0] + {{(BANG_W-QLO_W){1'b0}}, qlo_r};
  assign bang_flip = bang[BANG_W-1] ^ bang[BANG_W-2];
  assign bang_f    = {bang[BANG_W-1] ^ bang_flip, bang[BANG_W-2:0]};

  assign xf      = flip_r ? -cx : cx;
  assign yf      = flip_r ? -cy : cy;
  assign sin_q15 = to_q15(yf);
  assign cos_q15 = to_q15(xf);
  assign link_m  = signed'({{(MUL_W-LINK_W){1'b0}}, link_r});

  always_comb begin
    state_nxt   = state_r;
    iter_nxt    = iter_r;
    work_nxt    = work_r;
    sum_nxt     = sum_r;
    px_nxt      = px_r;
    py_nxt      = py_r;
    flip_nxt    = flip_r;
    qlo_nxt     = qlo_r;
    cos_nxt     = cos_r;
    out_x_nxt   = out_x_r;
    out_y_nxt   = out_y_r;
    out_vld_nxt = out_vld_r;
    link_nxt    = cfg_we ? cfg_wdata : link_r;
    mul_a       = '0;
    mul_b       = '0;
    cctl        = '0;
    cz0         = '0;
    in_rdy      = 1'b0;

    // Drop the held answer once the sink takes it
    if (out_vld_r && out_res.ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        in_rdy = !out_vld_r || out_res.ready;
        if (in_req.valid && in_rdy) begin
          // Answer with the current point right away, then start the move
          px_nxt      = start_x;
          py_nxt      = start_y;
          out_x_nxt   = start_xw[JOINT_W-1:0];
          out_y_nxt   = start_yw[JOINT_W-1:0];
          out_vld_nxt = 1'b1;
          work_nxt    = work_start;
          state_nxt   = S_WRAP;
        end
      end
      S_WRAP: begin
        // Wrap into one turn, one correction a cycle
        if (work_r[WORK_W-1]) begin
          work_nxt = work_r + WORK_TURN;
        end else if (work_r >= WORK_TURN) begin
          work_nxt = work_r - WORK_TURN;
        end else begin
          sum_nxt   = work_r[SUM_W-1:0];
          mul_a     = signed'({{(MUL_W-SUM_W){1'b0}}, work_r[SUM_W-1:0]});
          mul_b     = BA_REM;
          state_nxt = S_BA1;
        end
      end
      S_BA1: begin
        // Divide s*REM + BIAS by 1125 through the reciprocal
        mul_a     = mul_p[MUL_W-1:0] + BA_BIAS;
        mul_b     = BA_RECIP;
        state_nxt = S_BA2;
      end
      S_BA2: begin
        qlo_nxt   = mul_p[BA_SHIFT +: QLO_W];
        mul_a     = signed'({{(MUL_W-SUM_W){1'b0}}, sum_r});
        mul_b     = BA_QUOT;
        state_nxt = S_BA3;
      end
      S_BA3: begin
        flip_nxt  = bang_flip;
        cz0       = {bang_f[BANG_W-1], bang_f};
        cctl.load = 1'b1;
        iter_nxt  = '0;
        state_nxt = S_CORD;
      end
      S_CORD: begin
        cctl.step = 1'b1;
        cctl.idx  = iter_r;
        if (iter_r == ITER_LAST) begin
          state_nxt = S_ROUND;
        end else begin
          iter_nxt = iter_r + 1'b1;
        end
      end
      S_ROUND: begin
        cos_nxt   = cos_q15;
        mul_a     = link_m;
        mul_b     = {{(MUL_W-JOINT_W){sin_q15[JOINT_W-1]}}, sin_q15};
        state_nxt = S_STEPX;
      end
      S_STEPX: begin
        px_nxt    = sat_coord(px_w + step_trunc(mul_p));
        mul_a     = link_m;
        mul_b     = {{(MUL_W-JOINT_W){cos_r[JOINT_W-1]}}, cos_r};
        state_nxt = S_STEPY;
      end
      S_STEPY: begin
        py_nxt    = sat_coord(py_w + step_trunc(mul_p));
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      iter_r    <= '0;
      sum_r     <= '0;
      px_r      <= '0;
      py_r      <= '0;
      link_r    <= LINK_RESET;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      iter_r    <= iter_nxt;
      sum_r     <= sum_nxt;
      px_r      <= px_nxt;
      py_r      <= py_nxt;
      link_r    <= link_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Working payload, no reset
  always_ff @(posedge clk) begin
    work_r  <= work_nxt;
    flip_r  <= flip_nxt;
    qlo_r   <= qlo_nxt;
    cos_r   <= cos_nxt;
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
  end

  assign in_req.ready    = in_rdy;
  assign out_res.valid   = out_vld_r;
  assign out_res.joint_x = out_x_r;
  assign out_res.joint_y = out_y_r;

`ifndef SYNTHESIS
  a_accept_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req.valid && in_req.ready) |=> out_res.valid)
    else $error("accepted request left no answer");

  a_sum_in_turn: assert property (@(posedge clk) disable iff (!rst_n)
    sum_r < SUM_LIMIT)
    else $error("angle sum outside one turn");

  a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_req.ready)
    else $error("request taken while a joint is in progress");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CORD) |-> (iter_r <= ITER_LAST))
    else $error("rotation count past last step");
`endif

endmodule

>>> bench/planar_chain_joint_points_tb.sv
`timescale 1ns / 1ps

module planar_chain_joint_points_tb;
  import pcjp_pkg::*;

  // Cycles to let pass once the last point is back before the block counts as idle
  localparam int IDLE_SETTLE = CORDIC_STEPS + 16;
  // Receiver hold-off: starts after this many points and lasts this many cycles
  localparam int HOLDOFF_AFTER = 250;
  localparam int HOLDOFF_LEN   = 600;

  typedef struct packed {
    logic signed [JOINT_W-1:0] x;
    logic signed [JOINT_W-1:0] y;
  } joint_point_t;

  typedef enum int {
    RX_OPEN,
    RX_RANDOM,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_t;

  // Tracks the chain the way the block should: running angle sum, current
  // joint point and link length, and the points still owed by the block.
  class chain_scoreboard;
    localparam longint TURN_CENTIDEG = 36000;
    localparam longint TURN_BIAS     = 18000;
    localparam longint GAIN_START    = 652032874;
    localparam int     ATAN_LEN      = 24;

    joint_point_t      pending_points[$];
    logic [LINK_W-1:0] link_length;
    logic [SUM_W-1:0]  angle_sum;
    longint            point_x;
    longint            point_y;
    longint            atan_tab[ATAN_LEN];
    int                mismatches;

    function new();
      atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                   10679838, 5340245, 2670163, 1335087, 667544, 333772,
                   166886, 83443, 41722, 20861, 10430, 5215,
                   2608, 1304, 652, 326, 163, 81};
      link_length = LINK_RESET;
      angle_sum   = '0;
      point_x     = 0;
      point_y     = 0;
      mismatches  = 0;
    endfunction

    function void set_link(input logic [LINK_W-1:0] len);
      link_length = len;
    endfunction

    task report_mismatch(input string msg);
      mismatches++;
      $display("mismatch at %0t: %0s", $realtime, msg);
    endtask

    function longint clamp_coord(input longint v);
      longint half;
      half = longint'(1) <<< (COORD_BITS - 1);
      if (v < -half) return -half;
      if (v > half - 1) return half - 1;
      return v;
    endfunction

    function longint round_q15(input longint v);
      longint r;
      r = (v + (longint'(1) <<< 14)) >>> 15;
      if (r < -32768) return -32768;
      if (r > 32767) return 32767;
      return r;
    endfunction

    // Rotation-mode CORDIC on a binary angle; angles in the left half-plane
    // are turned by half a turn and the results negated afterwards.
    function void cordic_sin_cos(input logic [SUM_W-1:0] s, output longint sn,
                                 output longint cs);
      longint unsigned num;
      logic [31:0]     b;
      bit              flip;
      longint          x, y, z, nx;
      int              i;
      num  = (longint'(s) << 32) + TURN_BIAS;
      b    = 32'(num / TURN_CENTIDEG);
      flip = 1'b0;
      if (b >= 32'h4000_0000 && b < 32'hC000_0000) begin
        b    = b - 32'h8000_0000;
        flip = 1'b1;
      end
      x = GAIN_START;
      y = 0;
      z = longint'($signed(b));
      for (i = 0; i < CORDIC_STEPS && i < ATAN_LEN; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i);
          y  = y + (x >>> i);
          z  = z - atan_tab[i];
        end else begin
          nx = x + (y >>> i);
          y  = y - (x >>> i);
          z  = z + atan_tab[i];
        end
        x = nx;
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      cs = round_q15(x);
      sn = round_q15(y);
    endfunction

    // Owe the current point for this request, then advance the chain by it.
    function void note_request(input logic signed [ANG_W-1:0] ang, input logic start,
                               input logic signed [JOINT_W-1:0] bx,
                               input logic signed [JOINT_W-1:0] by);
      joint_point_t p;
      longint       r, sn, cs;
      if (start) begin
        angle_sum = '0;
        point_x   = clamp_coord(longint'(bx));
        point_y   = clamp_coord(longint'(by));
      end
      p.x = point_x[JOINT_W-1:0];
      p.y = point_y[JOINT_W-1:0];
      pending_points = {pending_points, p};
      r = (longint'(angle_sum) + longint'(ang)) % TURN_CENTIDEG;
      if (r < 0) r = r + TURN_CENTIDEG;
      angle_sum = r[SUM_W-1:0];
      cordic_sin_cos(angle_sum, sn, cs);
      point_x = clamp_coord(point_x + (longint'(link_length) * sn) / 32768);
      point_y = clamp_coord(point_y + (longint'(link_length) * cs) / 32768);
    endfunction

    task check_result(input logic signed [JOINT_W-1:0] jx,
                      input logic signed [JOINT_W-1:0] jy);
      joint_point_t want;
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("point (%0d,%0d) with no request waiting", jx, jy));
      end else begin
        want = pending_points.pop_front();
        if (jx !== want.x) begin
          report_mismatch($sformatf("joint_x got %0d want %0d", jx, want.x));
        end
        if (jy !== want.y) begin
          report_mismatch($sformatf("joint_y got %0d want %0d", jy, want.y));
        end
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [LINK_W-1:0] cfg_wdata;

  pcjp_in_if  in_req ();
  pcjp_out_if out_res ();

  planar_chain_joint_points i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .out_res   (out_res)
  );

  always #6 clk = ~clk;

  chain_scoreboard sb;
  int              results_seen = 0;
  int              burst_left = 0;
  int              gap_pct = 0;

  // Sample the result channel at the rising edge; values are the pre-edge ones.
  always @(posedge clk) begin
    if (rst_n && out_res.valid && out_res.ready) begin
      sb.check_result(out_res.joint_x, out_res.joint_y);
      results_seen++;
    end
  end

  // Receiver: change ready at the falling edge. Switch between stall patterns
  // every so often, and hold off once for a long stretch so that the block
  // backs up into its input while requests keep coming.
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       hold_left;
    int       phase_cnt;
    bit       holdoff_done;
    mode         = RX_OPEN;
    mode_left    = 0;
    hold_left    = 0;
    phase_cnt    = 0;
    holdoff_done = 1'b0;
    out_res.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      phase_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        out_res.ready = 1'b0;
      end else if (!holdoff_done && results_seen >= HOLDOFF_AFTER) begin
        holdoff_done  = 1'b1;
        hold_left     = HOLDOFF_LEN - 1;
        out_res.ready = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(RX_OPEN, RX_SPARSE));
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          RX_OPEN:     out_res.ready = 1'b1;
          RX_RANDOM:   out_res.ready = ($urandom_range(0, 99) < 70);
          RX_PERIODIC: out_res.ready = (phase_cnt % 5 != 0) && (phase_cnt % 7 != 3);
          default:     out_res.ready = ($urandom_range(0, 99) < 20);
        endcase
      end
    end
  end

  // Offer one request from the falling edge until it is taken, then decide
  // whether the burst goes on or a gap follows. Valid stays high across
  // back-to-back requests.
  task automatic send_request(input logic signed [ANG_W-1:0] ang, input logic start,
                              input logic signed [JOINT_W-1:0] bx,
                              input logic signed [JOINT_W-1:0] by);
    int gap;
    @(negedge clk);
    in_req.valid          = 1'b1;
    in_req.angle_centideg = ang;
    in_req.chain_start    = start;
    in_req.base_x         = bx;
    in_req.base_y         = by;
    do @(posedge clk); while (in_req.ready !== 1'b1);
    sb.note_request(ang, start, bx, by);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 99) < gap_pct) begin
        // Short gaps land inside one request's work, long ones may outlast it
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
        @(negedge clk);
        in_req.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  // Drop valid and wait until every owed point is back and the block has settled.
  task automatic wait_idle();
    @(negedge clk);
    in_req.valid = 1'b0;
    while (sb.pending_points.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  task automatic write_link(input logic [LINK_W-1:0] len);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = len;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_link(len);
  endtask

  function automatic logic signed [JOINT_W-1:0] pick_base();
    case ($urandom_range(0, 4))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return JOINT_W'(int'($urandom_range(0, 2000)) - 1000);
      default: return JOINT_W'($urandom());
    endcase
  endfunction

  // Mostly well-formed chains: a start request with a base point, then
  // joints. Now and then drop or repeat the start mark; base fields on
  // joint requests carry noise the block must ignore.
  task automatic run_random_chains(input int n_items);
    int                        sent;
    int                        chain_len;
    int                        j;
    int                        pick;
    logic signed [ANG_W-1:0]   ang;
    logic                      start;
    logic signed [JOINT_W-1:0] bx;
    logic signed [JOINT_W-1:0] by;
    sent = 0;
    while (sent < n_items) begin
      chain_len = $urandom_range(1, 8);
      for (j = 0; j < chain_len && sent < n_items; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          ang = ANG_W'(int'($urandom_range(0, 72000)) - 36000);
        end else if (pick < 90) begin
          ang = ANG_W'(4500 * (int'($urandom_range(0, 16)) - 8));
        end else begin
          ang = ANG_W'($urandom());
        end
        start = (j == 0);
        if ($urandom_range(0, 99) < 8) start = ~start;
        bx = pick_base();
        by = pick_base();
        send_request(ang, start, bx, by);
        sent++;
      end
    end
  endtask

  initial begin : main
    int                ph;
    logic [LINK_W-1:0] len;
    sb = new();
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_wdata             = '0;
    in_req.valid          = 1'b0;
    in_req.angle_centideg = '0;
    in_req.chain_start    = 1'b0;
    in_req.base_x         = '0;
    in_req.base_y         = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset link length, chain never started since reset
    gap_pct = 0;
    send_request(17'sd9000, 1'b0, 16'sd1234, -16'sd1234);
    send_request(17'sd0, 1'b0, 16'sd0, 16'sd0);
    // Base point extremes, then angle field extremes and quadrant edges
    send_request(17'sd0, 1'b1, 16'sh7FFF, 16'sh8000);
    send_request(17'sh0FFFF, 1'b0, 16'sh8000, 16'sh7FFF);
    send_request(17'sh10000, 1'b0, 16'shFFFF, 16'sh0000);
    send_request(17'sd36000, 1'b0, 16'sd0, 16'sd0);
    send_request(-17'sd36000, 1'b0, 16'sd0, 16'sd0);
    send_request(17'sd18000, 1'b1, 16'sh8000, 16'sh7FFF);
    send_request(17'sd27000, 1'b0, 16'sd0, 16'sd0);
    send_request(-17'sd9000, 1'b0, 16'sd0, 16'sd0);
    send_request(17'sd1, 1'b0, 16'sd0, 16'sd0);
    send_request(-17'sd1, 1'b0, 16'sd0, 16'sd0);
    send_request(17'sd35999, 1'b0, 16'sd0, 16'sd0);
    send_request(17'sd4500, 1'b1, 16'sd0, 16'sd0);

    // Longest link: walk off both corners to hit saturation
    write_link(10'd1023);
    send_request(17'sd4500, 1'b1, 16'sd32000, 16'sd32000);
    send_request(17'sd0, 1'b0, 16'sd0, 16'sd0);
    send_request(17'sd0, 1'b0, 16'sd0, 16'sd0);
    send_request(17'sd18000, 1'b1, -16'sd32000, -16'sd32000);
    send_request(17'sd0, 1'b0, 16'sd0, 16'sd0);
    send_request(17'sd0, 1'b0, 16'sd0, 16'sd0);

    // Zero link length: the point must stay put
    write_link(10'd0);
    send_request(17'sd9000, 1'b1, 16'sd100, -16'sd100);
    send_request(17'sd13500, 1'b0, 16'sd0, 16'sd0);
    send_request(-17'sd22500, 1'b0, 16'sd0, 16'sd0);

    // Random phases: vary link length and sender pressure between them
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       len = 10'd1023;
        1:       len = LINK_RESET;
        2:       len = 10'd0;
        3:       len = 10'd1;
        6:       len = 10'd512;
        default: len = LINK_W'($urandom_range(1, 1023));
      endcase
      gap_pct = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 35 : 80);
      write_link(len);
      run_random_chains(120);
    end

    // Drain, then settle before the verdict
    wait_idle();
    if (sb.pending_points.size() != 0) begin
      sb.report_mismatch($sformatf("%0d points never came", sb.pending_points.size()));
    end
    if (sb.mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin : watchdog
    #(5_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
